// ===== rtl/core/ikta_pkg.sv =====
// ikta_pkg: shared constants, operation codes, controller states and the
// command/status bundles between the argmin table controller and datapath.
// No dependencies.
`default_nettype none

package ikta_pkg;

  // field widths
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned INDEX_W = 8;
  localparam int unsigned KEY_W   = 17;
  localparam int unsigned COUNT_W = 9;

  // table sizing defaults
  localparam int unsigned MAX_ENTRIES_DEF = 256;
  localparam int unsigned COUNT_CAP       = 511;

  // empty key, 2.0 in unsigned Q2.15
  localparam logic [KEY_W-1:0]   KEY_EMPTY     = 17'h10000;
  localparam logic [COUNT_W-1:0] ENTRIES_RESET = 9'd256;

  // register file
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic        REG_ENTRIES = 1'b0;

  // operation codes
  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT   = 3'd0,
    MODE_UPDATE   = 3'd1,
    MODE_REMOVE   = 3'd2,
    MODE_CLEAR    = 3'd3,
    MODE_FIND_MIN = 3'd4,
    MODE_QUERY    = 3'd5
  } mode_t;

  // controller states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WRITE,
    ST_WIPE,
    ST_SCAN,
    ST_DRAIN,
    ST_REDUCE,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic rd_item;
    logic wr_item;
    logic clr_run;
    logic scan_run;
    logic reduce;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [MODE_W-1:0] in_mode;
    logic              clr_last;
    logic              scan_last;
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/ikta_regs.sv =====
// ikta_regs: APB register file holding the entry count register.
// Depends on ikta_pkg.
`default_nettype none

module ikta_regs (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [ikta_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [ikta_pkg::APB_DATA_W-1:0]     pwdata,
  output logic      [ikta_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                     pready,
  output logic                                     cfg_wr,
  output logic      [ikta_pkg::COUNT_W-1:0]        entries
);

  // write decode, register select by word address
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[2] == ikta_pkg::REG_ENTRIES);

  // entry count register
  always_ff @(posedge clk) begin
    if (rst) begin
      entries <= ikta_pkg::ENTRIES_RESET;
    end else if (cfg_wr) begin
      entries <= pwdata[ikta_pkg::COUNT_W-1:0];
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (paddr[2] == ikta_pkg::REG_ENTRIES) begin
      prdata = ikta_pkg::APB_DATA_W'(entries);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ikta_ctrl.sv =====
// ikta_ctrl: sequencer for table operations, clearing sweeps and the
// find-minimum scan; owns the channel handshakes. Depends on ikta_pkg.
`default_nettype none

module ikta_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  input  wire logic           cfg_wr,
  input  wire ikta_pkg::stat_t stat,
  output ikta_pkg::cmd_t      cmd
);

  ikta_pkg::state_t state, state_next;
  logic             out_valid_next;
  logic             accept;

  assign accept = (state == ikta_pkg::ST_IDLE) && in_valid && !cfg_wr;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ikta_pkg::ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    if (cfg_wr) begin
      state_next = ikta_pkg::ST_CLEAR;
    end else begin
      case (state)
        ikta_pkg::ST_CLEAR: begin
          if (stat.clr_last) state_next = ikta_pkg::ST_IDLE;
        end
        ikta_pkg::ST_IDLE: begin
          if (in_valid) begin
            case (stat.in_mode)
              ikta_pkg::MODE_INSERT,
              ikta_pkg::MODE_UPDATE,
              ikta_pkg::MODE_REMOVE,
              ikta_pkg::MODE_QUERY:    state_next = ikta_pkg::ST_READ;
              ikta_pkg::MODE_CLEAR:    state_next = ikta_pkg::ST_WIPE;
              ikta_pkg::MODE_FIND_MIN: state_next = ikta_pkg::ST_SCAN;
              default:                 state_next = ikta_pkg::ST_DONE;
            endcase
          end
        end
        ikta_pkg::ST_READ:   state_next = ikta_pkg::ST_WRITE;
        ikta_pkg::ST_WRITE:  state_next = ikta_pkg::ST_DONE;
        ikta_pkg::ST_WIPE: begin
          if (stat.clr_last) state_next = ikta_pkg::ST_DONE;
        end
        ikta_pkg::ST_SCAN: begin
          if (stat.scan_last) state_next = ikta_pkg::ST_DRAIN;
        end
        ikta_pkg::ST_DRAIN:  state_next = ikta_pkg::ST_REDUCE;
        ikta_pkg::ST_REDUCE: state_next = ikta_pkg::ST_DONE;
        ikta_pkg::ST_DONE: begin
          if (!out_valid || !out_stall) state_next = ikta_pkg::ST_IDLE;
        end
        default: state_next = ikta_pkg::ST_CLEAR;
      endcase
    end
  end

  // outputs
  always_comb begin
    in_stall     = (state != ikta_pkg::ST_IDLE) || cfg_wr;
    cmd.capture  = accept;
    cmd.rd_item  = (state == ikta_pkg::ST_READ);
    cmd.wr_item  = (state == ikta_pkg::ST_WRITE);
    cmd.clr_run  = ((state == ikta_pkg::ST_CLEAR) || (state == ikta_pkg::ST_WIPE)) && !cfg_wr;
    cmd.scan_run = (state == ikta_pkg::ST_SCAN);
    cmd.reduce   = (state == ikta_pkg::ST_REDUCE);
    cmd.out_load = (state == ikta_pkg::ST_DONE) && (!out_valid || !out_stall);

    // output slot: filled on load, emptied when taken
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ikta_datapath.sv =====
// ikta_datapath: key/active memory, clearing and scan counters, four-lane
// minimum tracking, lane reduction and result registers. Depends on ikta_pkg.
`default_nettype none

module ikta_datapath #(
  parameter int unsigned MAX_ENTRIES = ikta_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire ikta_pkg::cmd_t                     cmd,
  output ikta_pkg::stat_t                         stat,
  input  wire logic [ikta_pkg::COUNT_W-1:0]       entries,
  input  wire logic [ikta_pkg::MODE_W-1:0]        mode,
  input  wire logic [ikta_pkg::INDEX_W-1:0]       index,
  input  wire logic [ikta_pkg::KEY_W-1:0]         key,
  output logic      [ikta_pkg::COUNT_W-1:0]       min_index,
  output logic                                    entry_active
);

  localparam int unsigned KW   = ikta_pkg::KEY_W;
  localparam int unsigned CNW  = ikta_pkg::COUNT_W;
  localparam int unsigned AW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned NCAP = (MAX_ENTRIES < ikta_pkg::COUNT_CAP) ? MAX_ENTRIES
                                                                      : ikta_pkg::COUNT_CAP;
  localparam int unsigned SPAN_MAX = ((NCAP + 3) / 4) * 4;
  localparam int unsigned SW   = $clog2(SPAN_MAX + 1);
  localparam int unsigned IW0  = (AW > SW) ? AW : SW;
  localparam int unsigned IW   = (IW0 > ikta_pkg::INDEX_W) ? IW0 : ikta_pkg::INDEX_W;
  localparam logic [IW:0]     MAX_V  = (IW + 1)'(MAX_ENTRIES);
  localparam logic [CNW-1:0]  NCAP_V = CNW'(NCAP);
  localparam logic [AW-1:0]   CLR_LAST_V = AW'(MAX_ENTRIES - 1);

  // memory word: active bit over key
  logic [KW:0]    mem [MAX_ENTRIES];
  logic [KW:0]    rd_data;
  logic           we;
  logic [AW-1:0]  waddr;
  logic [AW-1:0]  raddr;
  logic [KW:0]    wdata;

  // item registers
  logic [ikta_pkg::MODE_W-1:0]  it_mode;
  logic [ikta_pkg::INDEX_W-1:0] it_index;
  logic [KW-1:0]                it_key;
  logic [KW-1:0]                key_sat;
  logic [IW-1:0]                it_index_ext;
  logic                         in_range;

  // live count and scan span
  logic [CNW-1:0] n;
  logic [9:0]     n_p3;
  logic [9:0]     span10;
  logic [SW-1:0]  span;

  // counters and scan pipeline
  logic [AW-1:0]  clr_cnt;
  logic [SW-1:0]  scan_i;
  logic [IW-1:0]  scan_ext;
  logic           scan_oob;
  logic           vld_d;
  logic           oob_d;
  logic [SW-1:0]  idx_d;
  logic [KW-1:0]  key_rd;
  logic [1:0]     lane;

  // lane bests and reduction
  logic [KW-1:0]  best_key [4];
  logic [SW-1:0]  best_idx [4];
  logic [KW-1:0]  win_key;
  logic [SW-1:0]  win_idx;
  logic [9:0]     win_ext;
  logic [CNW-1:0] win_clamped;

  logic [CNW-1:0] last_min;
  logic           res_active;

  // count saturation and span rounded up to four lanes
  always_comb begin
    n      = (entries > NCAP_V) ? NCAP_V : entries;
    n_p3   = 10'(n) + 10'd3;
    span10 = {n_p3[9:2], 2'b00};
    if (span10 == 10'd0) span10 = 10'd4;
    span   = span10[SW-1:0];
  end

  // key saturation at 2.0 and index range check
  assign key_sat      = (key > ikta_pkg::KEY_EMPTY) ? ikta_pkg::KEY_EMPTY : key;
  assign it_index_ext = IW'(it_index);
  assign in_range     = (CNW'(it_index) < n);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it_mode  <= mode;
      it_index <= index;
      it_key   <= key_sat;
    end
  end

  // clearing sweep counter
  always_ff @(posedge clk) begin
    if (rst || !cmd.clr_run) begin
      clr_cnt <= '0;
    end else begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  // scan counter
  always_ff @(posedge clk) begin
    if (rst || !cmd.scan_run) begin
      scan_i <= '0;
    end else begin
      scan_i <= scan_i + SW'(1);
    end
  end

  assign scan_ext = IW'(scan_i);
  assign scan_oob = ({1'b0, scan_ext} >= MAX_V);

  assign stat.in_mode   = mode;
  assign stat.clr_last  = (clr_cnt == CLR_LAST_V);
  assign stat.scan_last = (scan_i == span - SW'(1));

  // memory port selection
  always_comb begin
    we    = 1'b0;
    waddr = it_index_ext[AW-1:0];
    wdata = {1'b0, ikta_pkg::KEY_EMPTY};
    raddr = cmd.scan_run ? scan_ext[AW-1:0] : it_index_ext[AW-1:0];
    if (cmd.clr_run) begin
      we    = 1'b1;
      waddr = clr_cnt;
    end else if (cmd.wr_item && in_range) begin
      case (it_mode)
        ikta_pkg::MODE_INSERT: begin
          we    = 1'b1;
          wdata = {1'b1, it_key};
        end
        ikta_pkg::MODE_UPDATE: begin
          we    = 1'b1;
          wdata = {rd_data[KW], it_key};
        end
        ikta_pkg::MODE_REMOVE: begin
          we    = 1'b1;
        end
        default: we = 1'b0;
      endcase
    end
  end

  // key/active memory
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (cmd.rd_item || cmd.scan_run) rd_data <= mem[raddr];
  end

  // scan read tagging
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_d <= 1'b0;
    end else begin
      vld_d <= cmd.scan_run;
    end
    idx_d <= scan_i;
    oob_d <= scan_oob;
  end

  assign key_rd = oob_d ? ikta_pkg::KEY_EMPTY : rd_data[KW-1:0];
  assign lane   = idx_d[1:0];

  // per-lane minimum, earliest strictly smaller wins
  always_ff @(posedge clk) begin
    if (vld_d) begin
      if ((idx_d[SW-1:2] == '0) || (key_rd < best_key[lane])) begin
        best_key[lane] <= key_rd;
        best_idx[lane] <= idx_d;
      end
    end
  end

  // lane reduction, lowest lane keeps ties, then clamp to count
  always_comb begin
    win_key = best_key[0];
    win_idx = best_idx[0];
    for (int l = 1; l < 4; l++) begin
      if (best_key[l] < win_key) begin
        win_key = best_key[l];
        win_idx = best_idx[l];
      end
    end
    win_ext     = 10'(win_idx);
    win_clamped = (win_ext > 10'(n)) ? n : win_ext[CNW-1:0];
  end

  // last found index
  always_ff @(posedge clk) begin
    if (cmd.clr_run && stat.clr_last) begin
      last_min <= n;
    end else if (cmd.reduce) begin
      last_min <= win_clamped;
    end
  end

  // query result
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res_active <= 1'b0;
    end else if (cmd.wr_item && (it_mode == ikta_pkg::MODE_QUERY)) begin
      res_active <= in_range & rd_data[KW];
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      min_index    <= last_min;
      entry_active <= res_active;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/indexed_key_table_argmin_core.sv =====
// Insert, update, remove and query step through read, write and done states
// after acceptance; find-minimum scans span slots, span = entry count rounded
// up to 4 (min 4), with one key memory read per scanned slot, then drains and
// reduces the lanes; clear-all runs the one-entry-per-cycle clearing sweep.
// Reset (and any write to the entry count) runs that sweep with in_stall high.
// One item in flight at a time: in_stall stays high until the block is idle.
`default_nettype none

module indexed_key_table_argmin_core #(
  parameter int unsigned MAX_ENTRIES = ikta_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // input channel
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [ikta_pkg::MODE_W-1:0]         mode,
  input  wire logic [ikta_pkg::INDEX_W-1:0]        index,
  input  wire logic [ikta_pkg::KEY_W-1:0]          key,
  // output channel
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic      [ikta_pkg::COUNT_W-1:0]        min_index,
  output logic                                     entry_active,
  // configuration
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [ikta_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [ikta_pkg::APB_DATA_W-1:0]     pwdata,
  output logic      [ikta_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                     pready
);

  ikta_pkg::cmd_t              cmd;
  ikta_pkg::stat_t             stat;
  logic                        cfg_wr;
  logic [ikta_pkg::COUNT_W-1:0] entries;

  // register file
  ikta_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_wr  (cfg_wr),
    .entries (entries)
  );

  // sequencer
  ikta_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_wr    (cfg_wr),
    .stat      (stat),
    .cmd       (cmd)
  );

  // table datapath
  ikta_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .entries      (entries),
    .mode         (mode),
    .index        (index),
    .key          (key),
    .min_index    (min_index),
    .entry_active (entry_active)
  );

endmodule

`default_nettype wire

// ===== verif/indexed_key_table_argmin_core_tb.sv =====
// indexed_key_table_argmin_core_tb: self-checking bench for the argmin key table core
// drives table operations on the input channel and entry-count writes over APB, and
// checks every result against a mirror of the table; needs ikta_pkg and the core RTL

module indexed_key_table_argmin_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ikta_pkg::*;

  localparam int unsigned TABLE_SLOTS     = MAX_ENTRIES_DEF;
  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int unsigned ITEMS_PER_PHASE = 100;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned HOLD_AFTER      = 150;
  localparam int unsigned SETTLE_CYCLES   = 16;

  // mode encodings the block leaves unused
  localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;

  localparam logic [APB_ADDR_W-1:0] ADDR_ENTRIES = {REG_ENTRIES, 2'b00};

  // entry-count settings walked by the random phases, extremes included
  localparam int unsigned PHASE_COUNTS [7] = '{0, 1, 5, 13, 256, 511, 130};

  // small keys that crowd together so lanes and slots tie
  localparam logic [KEY_W-1:0] TIE_KEYS [4] = '{17'h00000, 17'h00001, 17'h07FFF, 17'h0FFFF};

  typedef struct packed {
    logic [COUNT_W-1:0] min_index;
    logic               entry_active;
  } table_result_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [INDEX_W-1:0] index;
    logic [KEY_W-1:0]   key;
    logic               typed;
    table_result_t      want;
  } directed_row_t;

  // directed transactions at the reset entry count of 256
  localparam directed_row_t DIRECTED [25] = '{
    '{MODE_QUERY,    8'd0,   17'h00000, 1'b1, '{9'd256, 1'b0}},
    '{MODE_FIND_MIN, 8'd0,   17'h00000, 1'b1, '{9'd0,   1'b0}},
    '{MODE_INSERT,   8'd255, 17'h00000, 1'b1, '{9'd0,   1'b0}},
    '{MODE_FIND_MIN, 8'd0,   17'h00000, 1'b1, '{9'd255, 1'b0}},
    '{MODE_INSERT,   8'd0,   17'h1FFFF, 1'b0, '0},
    '{MODE_QUERY,    8'd0,   17'h00000, 1'b1, '{9'd255, 1'b1}},
    '{MODE_UPDATE,   8'd255, 17'h10000, 1'b0, '0},
    '{MODE_FIND_MIN, 8'd0,   17'h00000, 1'b0, '0},
    '{MODE_INSERT,   8'd3,   17'h00000, 1'b0, '0},
    '{MODE_INSERT,   8'd2,   17'h00000, 1'b0, '0},
    '{MODE_FIND_MIN, 8'd0,   17'h00000, 1'b0, '0},
    '{MODE_INSERT,   8'd6,   17'h00000, 1'b0, '0},
    '{MODE_FIND_MIN, 8'd0,   17'h00000, 1'b0, '0},
    '{MODE_REMOVE,   8'd2,   17'h00000, 1'b0, '0},
    '{MODE_FIND_MIN, 8'd0,   17'h00000, 1'b0, '0},
    '{MODE_QUERY,    8'd2,   17'h00000, 1'b0, '0},
    '{MODE_INSERT,   8'd128, 17'h0FFFF, 1'b0, '0},
    '{MODE_UPDATE,   8'd128, 17'h00001, 1'b0, '0},
    '{MODE_SPARE_A,  8'd255, 17'h1FFFF, 1'b0, '0},
    '{MODE_SPARE_B,  8'd170, 17'h0AAAA, 1'b0, '0},
    '{MODE_INSERT,   8'd85,  17'h15555, 1'b0, '0},
    '{MODE_CLEAR,    8'd0,   17'h00000, 1'b1, '{9'd256, 1'b0}},
    '{MODE_QUERY,    8'd6,   17'h00000, 1'b1, '{9'd256, 1'b0}},
    '{MODE_FIND_MIN, 8'd0,   17'h00000, 1'b1, '{9'd0,   1'b0}},
    '{MODE_QUERY,    8'd255, 17'h1FFFF, 1'b1, '{9'd0,   1'b0}}
  };

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [MODE_W-1:0]     mode;
  logic [INDEX_W-1:0]    index;
  logic [KEY_W-1:0]      key;
  logic                  out_valid;
  logic                  out_stall;
  logic [COUNT_W-1:0]    min_index;
  logic                  entry_active;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // table mirror
  logic [KEY_W-1:0]   keys_mirror [TABLE_SLOTS];
  bit                 active_mirror [TABLE_SLOTS];
  logic [COUNT_W-1:0] min_mirror;
  logic [COUNT_W-1:0] entries_reg;

  table_result_t awaited [$];

  bit          calm = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned results_checked = 0;
  int unsigned items_sent = 0;
  int unsigned scans_sent = 0;
  int unsigned configs_done = 0;

  indexed_key_table_argmin_core #(
    .MAX_ENTRIES(TABLE_SLOTS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .mode(mode),
    .index(index),
    .key(key),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .min_index(min_index),
    .entry_active(entry_active),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // effective entry count, saturated to the table size
  function automatic int unsigned live_slots();
    return (entries_reg > TABLE_SLOTS) ? TABLE_SLOTS : entries_reg;
  endfunction

  function automatic void wipe_mirror();
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      keys_mirror[i] = KEY_EMPTY;
      active_mirror[i] = 1'b0;
    end
    min_mirror = COUNT_W'(live_slots());
  endfunction

  // applies one operation to the mirror and returns the result it should produce
  function automatic table_result_t apply_table_op(input logic [MODE_W-1:0] m,
                                                   input logic [INDEX_W-1:0] ix,
                                                   input logic [KEY_W-1:0] k);
    int unsigned      n;
    int unsigned      span;
    int unsigned      win;
    int unsigned      lane_idx [4];
    logic [KEY_W-1:0] lane_key [4];
    logic [KEY_W-1:0] win_key;
    logic [KEY_W-1:0] probe;
    logic [KEY_W-1:0] kin;
    bit               hit;
    table_result_t    res;
    n = live_slots();
    hit = ix < n;
    kin = (k > KEY_EMPTY) ? KEY_EMPTY : k;
    res.entry_active = 1'b0;
    case (m)
      MODE_INSERT: begin
        if (hit) begin
          active_mirror[ix] = 1'b1;
          keys_mirror[ix] = kin;
        end
      end
      MODE_UPDATE: begin
        if (hit) keys_mirror[ix] = kin;
      end
      MODE_REMOVE: begin
        if (hit) begin
          active_mirror[ix] = 1'b0;
          keys_mirror[ix] = KEY_EMPTY;
        end
      end
      MODE_CLEAR: begin
        wipe_mirror();
      end
      MODE_FIND_MIN: begin
        // four lanes by slot mod 4, earliest strictly smaller key per lane
        span = ((n + 3) / 4) * 4;
        if (span < 4) span = 4;
        for (int i = 0; i < span; i++) begin
          probe = (i < TABLE_SLOTS) ? keys_mirror[i] : KEY_EMPTY;
          if (i < 4 || probe < lane_key[i % 4]) begin
            lane_key[i % 4] = probe;
            lane_idx[i % 4] = i;
          end
        end
        // lower lane keeps ties
        win = lane_idx[0];
        win_key = lane_key[0];
        for (int l = 1; l < 4; l++) begin
          if (lane_key[l] < win_key) begin
            win_key = lane_key[l];
            win = lane_idx[l];
          end
        end
        min_mirror = COUNT_W'((win > n) ? n : win);
      end
      MODE_QUERY: begin
        if (hit) res.entry_active = active_mirror[ix];
      end
      default: ;
    endcase
    res.min_index = min_mirror;
    return res;
  endfunction

  function automatic logic [KEY_W-1:0] draw_key();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 30) return TIE_KEYS[$urandom_range(3)];
    if (r < 70) return KEY_W'($urandom_range(32'h10000));
    if (r < 85) return KEY_W'($urandom_range(32'h1FFFF, 32'h10001));
    return KEY_EMPTY;
  endfunction

  // mostly slots in use, sometimes anywhere in the index range
  function automatic logic [INDEX_W-1:0] draw_index(input int unsigned n);
    if (n > 0 && $urandom_range(99) < 85) return INDEX_W'($urandom_range(n - 1));
    return INDEX_W'($urandom_range(255));
  endfunction

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  // offers one transaction, holds it until accepted, then records its outcome
  task automatic push_op(input logic [MODE_W-1:0] m, input logic [INDEX_W-1:0] ix,
                         input logic [KEY_W-1:0] k, input bit typed, input table_result_t want);
    table_result_t predicted;
    @(negedge clk);
    while (!calm && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    index <= ix;
    key <= k;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = apply_table_op(m, ix, k);
    awaited.push_back(typed ? want : predicted);
    items_sent++;
    if (m == MODE_FIND_MIN) scans_sent++;
  endtask

  // result side: random stalls, one long hold-off so the block backs up
  initial begin
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && results_checked >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 19);
      end
    end
  end

  // result checking and run limit
  always @(posedge clk) begin
    table_result_t exp_res;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout at cycle %0d with %0d results outstanding", cycle_count,
               awaited.size());
      $display("[FAIL] regression broken");
      $finish;
    end else if (!rst && out_valid && !out_stall) begin
      if (awaited.size() == 0) begin
        flag_mismatch($sformatf("unexpected transaction min_index=%0d entry_active=%0b",
                                min_index, entry_active));
      end else begin
        exp_res = awaited.pop_front();
        if (min_index !== exp_res.min_index)
          flag_mismatch($sformatf("min_index %0d, expected %0d", min_index,
                                  exp_res.min_index));
        if (entry_active !== exp_res.entry_active)
          flag_mismatch($sformatf("entry_active %0b, expected %0b", entry_active,
                                  exp_res.entry_active));
        results_checked++;
      end
    end
  end

  // stimulus
  initial begin
    int unsigned        n;
    int unsigned        start;
    int unsigned        r;
    int unsigned        burst_len;
    logic [MODE_W-1:0]  m;
    logic [INDEX_W-1:0] popped;
    rst = 1'b1;
    in_valid = 1'b0;
    mode = MODE_INSERT;
    index = '0;
    key = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    entries_reg = ENTRIES_RESET;
    wipe_mirror();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table, checked at the reset entry count
    foreach (DIRECTED[i])
      push_op(DIRECTED[i].mode, DIRECTED[i].index, DIRECTED[i].key, DIRECTED[i].typed,
              DIRECTED[i].want);

    for (int p = 0; p < $size(PHASE_COUNTS); p++) begin
      // drain before reprogramming the entry count
      @(negedge clk);
      in_valid <= 1'b0;
      while (awaited.size() != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);

      // apb write, then read back
      @(negedge clk);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= ADDR_ENTRIES;
      pwdata <= APB_DATA_W'(PHASE_COUNTS[p]);
      @(negedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
      entries_reg = COUNT_W'(PHASE_COUNTS[p]);
      wipe_mirror();
      configs_done++;
      @(negedge clk);
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(negedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
      if (prdata !== APB_DATA_W'(PHASE_COUNTS[p]))
        flag_mismatch($sformatf("entry count reads %0d, wrote %0d", prdata, PHASE_COUNTS[p]));
      @(negedge clk);
      psel <= 1'b0;
      penable <= 1'b0;

      // one phase runs with no idling on either side
      calm = (p == 4);
      n = live_slots();
      start = items_sent;
      while (items_sent - start < ITEMS_PER_PHASE) begin
        if ($urandom_range(99) < 65) begin
          // priority-queue pattern: load keys, find the minimum, pop and query it
          burst_len = $urandom_range(8, 2);
          repeat (burst_len)
            push_op(($urandom_range(99) < 75) ? MODE_INSERT : MODE_UPDATE, draw_index(n),
                    draw_key(), 1'b0, '0);
          push_op(MODE_FIND_MIN, draw_index(n), draw_key(), 1'b0, '0);
          popped = INDEX_W'(min_mirror);
          push_op(MODE_REMOVE, popped, draw_key(), 1'b0, '0);
          push_op(MODE_QUERY, popped, draw_key(), 1'b0, '0);
        end else begin
          r = $urandom_range(99);
          if (r < 20) m = MODE_INSERT;
          else if (r < 35) m = MODE_UPDATE;
          else if (r < 50) m = MODE_REMOVE;
          else if (r < 55) m = MODE_CLEAR;
          else if (r < 70) m = MODE_FIND_MIN;
          else if (r < 92) m = MODE_QUERY;
          else if (r < 96) m = MODE_SPARE_A;
          else m = MODE_SPARE_B;
          push_op(m, draw_index(n), draw_key(), 1'b0, '0);
        end
      end
      calm = 1'b0;
    end

    // wind down
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("ran %0d table transactions, %0d of them minimum scans, over %0d entry counts",
             items_sent, scans_sent, configs_done + 1);
    $display("%0d results compared, %0d mismatches", results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
